// ----- hw/rtl/qthm_pkg.sv -----
// Shared types and constants of the quaternion to homogeneous matrix unit.
// No dependencies; the top level imports it.
package qthm_pkg;

  localparam int QUAT_WIDTH = 16;
  localparam int FRAC_BITS  = QUAT_WIDTH - 2;
  localparam int SHIFT_WIDTH = 32;
  // Widths of products, sums of squares and signed numerators.
  localparam int PROD_WIDTH = 2 * QUAT_WIDTH;
  localparam int DEN_WIDTH  = 2 * QUAT_WIDTH + 1;
  localparam int NUM_WIDTH  = 2 * QUAT_WIDTH + 2;
  localparam int LANES      = 9;

  typedef logic signed [QUAT_WIDTH-1:0]  quat_t;
  typedef logic signed [SHIFT_WIDTH-1:0] shift_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [NUM_WIDTH-1:0]   num_t;
  typedef logic [DEN_WIDTH-1:0]          den_t;
  typedef logic [FRAC_BITS:0]            quo_t;

  typedef struct packed {
    quat_t  quat_x;
    quat_t  quat_y;
    quat_t  quat_z;
    quat_t  quat_w;
    shift_t shift_x;
    shift_t shift_y;
    shift_t shift_z;
  } pose_t;

  typedef struct packed {
    quat_t  r00;
    quat_t  r01;
    quat_t  r02;
    quat_t  r10;
    quat_t  r11;
    quat_t  r12;
    quat_t  r20;
    quat_t  r21;
    quat_t  r22;
    shift_t out_shift_x;
    shift_t out_shift_y;
    shift_t out_shift_z;
  } frame_t;

  function automatic num_t ext(input prod_t p);
    return num_t'(p);
  endfunction

endpackage

// ----- hw/rtl/quaternion_to_homogeneous_matrix_unit.sv -----
// Top level of the quaternion to homogeneous matrix unit: a fully pipelined
// datapath from pose words to rotation-matrix words. Depends on qthm_pkg.
//
// Each pose word carries a quaternion in signed Q2.14 and a translation in
// signed Q16.16. The unit returns the nine rotation entries in signed Q2.14,
// each divided exactly by x^2+y^2+z^2+w^2 and rounded to nearest (ties away
// from zero), so the quaternion need not be normalized; a zero quaternion
// yields an all-zero rotation. The translation passes through unchanged.
// One word is accepted every cycle while frame_stall does not hold the
// pipeline. The stages are one of multipliers, one of adders, one that
// forms magnitudes and the integer quotient bit, one restoring division
// step per fraction bit across all nine lanes, and a final rounding
// stage. The whole pipeline holds while a finished word waits on
// frame_stall.
module quaternion_to_homogeneous_matrix_unit (
  input  logic            clk,
  input  logic            rst,
  input  qthm_pkg::pose_t  pose,
  input  logic            pose_valid,
  output logic            pose_stall,
  output qthm_pkg::frame_t frame,
  output logic            frame_valid,
  input  logic            frame_stall
);
  import qthm_pkg::*;

  // The pipeline advances whenever the output register is free or drained.
  logic adv;
  assign adv        = !frame_valid || !frame_stall;
  assign pose_stall = !adv;

  // Stage 1: the four squares and six cross products.
  logic  p_valid;
  prod_t xx, yy, zz, ww, xy, zw, xz, yw, yz, xw;
  shift_t p_sx, p_sy, p_sz;

  // Stage 2: the denominator and the nine signed numerators.
  logic s_valid;
  den_t s_den;
  num_t s_num [LANES];
  shift_t s_sx, s_sy, s_sz;

  // Division stages; index j holds the state after j fraction steps.
  logic   it_valid [FRAC_BITS+1];
  den_t   it_den   [FRAC_BITS+1];
  logic   it_zero  [FRAC_BITS+1];
  logic   it_neg   [FRAC_BITS+1][LANES];
  den_t   it_rem   [FRAC_BITS+1][LANES];
  quo_t   it_quo   [FRAC_BITS+1][LANES];
  shift_t it_sx    [FRAC_BITS+1];
  shift_t it_sy    [FRAC_BITS+1];
  shift_t it_sz    [FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      xx <= pose.quat_x * pose.quat_x;
      yy <= pose.quat_y * pose.quat_y;
      zz <= pose.quat_z * pose.quat_z;
      ww <= pose.quat_w * pose.quat_w;
      xy <= pose.quat_x * pose.quat_y;
      zw <= pose.quat_z * pose.quat_w;
      xz <= pose.quat_x * pose.quat_z;
      yw <= pose.quat_y * pose.quat_w;
      yz <= pose.quat_y * pose.quat_z;
      xw <= pose.quat_x * pose.quat_w;
      p_sx <= pose.shift_x;
      p_sy <= pose.shift_y;
      p_sz <= pose.shift_z;
    end
  end

  // Squares are never negative, so the denominator is summed unsigned.
  always_ff @(posedge clk) begin
    if (adv) begin
      s_den <= DEN_WIDTH'($unsigned(xx)) + DEN_WIDTH'($unsigned(yy))
             + DEN_WIDTH'($unsigned(zz)) + DEN_WIDTH'($unsigned(ww));
      s_num[0] <= ext(xx) - ext(yy) - ext(zz) + ext(ww);
      s_num[1] <= (ext(xy) - ext(zw)) <<< 1;
      s_num[2] <= (ext(xz) + ext(yw)) <<< 1;
      s_num[3] <= (ext(xy) + ext(zw)) <<< 1;
      s_num[4] <= ext(yy) - ext(xx) - ext(zz) + ext(ww);
      s_num[5] <= (ext(yz) - ext(xw)) <<< 1;
      s_num[6] <= (ext(xz) - ext(yw)) <<< 1;
      s_num[7] <= (ext(yz) + ext(xw)) <<< 1;
      s_num[8] <= ext(zz) - ext(xx) - ext(yy) + ext(ww);
      s_sx <= p_sx;
      s_sy <= p_sy;
      s_sz <= p_sz;
    end
  end

  // Every numerator magnitude is at most the denominator, so it fits in
  // DEN_WIDTH bits and the integer part of the quotient is a single bit.
  den_t        mag0   [LANES];
  logic [DEN_WIDTH:0] twice [FRAC_BITS+1][LANES];
  logic        take   [FRAC_BITS+1][LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag0[l] = s_num[l][NUM_WIDTH-1] ? DEN_WIDTH'(-s_num[l]) : DEN_WIDTH'(s_num[l]);
    end
    for (int j = 0; j <= FRAC_BITS; j++) begin
      for (int l = 0; l < LANES; l++) begin
        twice[j][l] = {it_rem[j][l], 1'b0};
        take[j][l]  = twice[j][l] >= {1'b0, it_den[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_den[0]  <= s_den;
      it_zero[0] <= (s_den == '0);
      it_sx[0]   <= s_sx;
      it_sy[0]   <= s_sy;
      it_sz[0]   <= s_sz;
      for (int l = 0; l < LANES; l++) begin
        it_neg[0][l] <= s_num[l][NUM_WIDTH-1];
        if (mag0[l] >= s_den) begin
          it_quo[0][l] <= quo_t'(1);
          it_rem[0][l] <= '0;
        end else begin
          it_quo[0][l] <= '0;
          it_rem[0][l] <= mag0[l];
        end
      end
      for (int j = 1; j <= FRAC_BITS; j++) begin
        it_den[j]  <= it_den[j-1];
        it_zero[j] <= it_zero[j-1];
        it_sx[j]   <= it_sx[j-1];
        it_sy[j]   <= it_sy[j-1];
        it_sz[j]   <= it_sz[j-1];
        for (int l = 0; l < LANES; l++) begin
          it_neg[j][l] <= it_neg[j-1][l];
          it_quo[j][l] <= {it_quo[j-1][l][FRAC_BITS-1:0], take[j-1][l]};
          if (take[j-1][l]) begin
            it_rem[j][l] <= DEN_WIDTH'(twice[j-1][l] - {1'b0, it_den[j-1]});
          end else begin
            it_rem[j][l] <= DEN_WIDTH'(twice[j-1][l]);
          end
        end
      end
    end
  end

  // Final stage: round on the magnitude, then apply the sign. The rounded
  // magnitude never exceeds 1.0, which the signed Q2.14 range holds.
  quat_t ent [LANES];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [QUAT_WIDTH-1:0] rq;
      rq = QUAT_WIDTH'(it_quo[FRAC_BITS][l]) + QUAT_WIDTH'(take[FRAC_BITS][l]);
      if (it_zero[FRAC_BITS]) begin
        ent[l] = '0;
      end else if (it_neg[FRAC_BITS][l]) begin
        ent[l] = -$signed(rq);
      end else begin
        ent[l] = $signed(rq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frame.r00 <= ent[0];
      frame.r01 <= ent[1];
      frame.r02 <= ent[2];
      frame.r10 <= ent[3];
      frame.r11 <= ent[4];
      frame.r12 <= ent[5];
      frame.r20 <= ent[6];
      frame.r21 <= ent[7];
      frame.r22 <= ent[8];
      frame.out_shift_x <= it_sx[FRAC_BITS];
      frame.out_shift_y <= it_sy[FRAC_BITS];
      frame.out_shift_z <= it_sz[FRAC_BITS];
    end
  end

  // Valid bits travel alongside the data and hold during a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid     <= 1'b0;
      s_valid     <= 1'b0;
      frame_valid <= 1'b0;
      for (int j = 0; j <= FRAC_BITS; j++) begin
        it_valid[j] <= 1'b0;
      end
    end else if (adv) begin
      p_valid     <= pose_valid;
      s_valid     <= p_valid;
      it_valid[0] <= s_valid;
      for (int j = 1; j <= FRAC_BITS; j++) begin
        it_valid[j] <= it_valid[j-1];
      end
      frame_valid <= it_valid[FRAC_BITS];
    end
  end

`ifndef SYNTH
  localparam logic signed [QUAT_WIDTH-1:0] ONE = QUAT_WIDTH'(1) <<< FRAC_BITS;

  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (frame.r00 <= ONE && frame.r00 >= -ONE &&
                     frame.r11 <= ONE && frame.r11 >= -ONE &&
                     frame.r22 <= ONE && frame.r22 >= -ONE))
    else $error("diagonal entry beyond unit magnitude");

  a_offd_range: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (frame.r01 <= ONE && frame.r01 >= -ONE &&
                     frame.r12 <= ONE && frame.r12 >= -ONE))
    else $error("off-diagonal entry beyond unit magnitude");

  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(it_valid[0]) && $stable(it_valid[FRAC_BITS]) &&
              $stable(p_valid) && $stable(s_valid)))
    else $error("pipeline moved during a stall");
`endif

endmodule
